### hw/rtl/hgdm_pkg.sv
// ----------------------------------------------------------------------------
// hgdm_pkg
// Shared types, codes and the per-gesture distance rule table of the hand
// gesture distance matcher.
// ----------------------------------------------------------------------------
package hgdm_pkg;

  localparam int COORD_W   = 16;
  localparam int NUM_SLOTS = 6;
  localparam int SLOT_W    = 3;
  localparam int GEST_W    = 3;
  localparam int IDX_W     = 3;
  // Squared limits reach 20000^2, squared distances 3 * 65535^2
  localparam int LIM_W     = 29;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = 34;

  // Palm normal threshold, 0.5 in Q1.14
  localparam logic signed [COORD_W-1:0] NORMAL_HALF = 16'sd8192;

  // Point slots
  localparam logic [SLOT_W-1:0] SLOT_THUMB  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_INDEX  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_MIDDLE = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_RING   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_PINKY  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_PALM   = 3'd5;

  // Item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // Gesture codes
  localparam logic [GEST_W-1:0] GEST_OPEN        = 3'd0;
  localparam logic [GEST_W-1:0] GEST_EMPTY_HOLD  = 3'd1;
  localparam logic [GEST_W-1:0] GEST_SOLID_HOLD  = 3'd2;
  localparam logic [GEST_W-1:0] GEST_POINT       = 3'd3;
  localparam logic [GEST_W-1:0] GEST_INDEX_TOUCH = 3'd4;
  localparam logic [GEST_W-1:0] GEST_PINKY_TOUCH = 3'd5;

  typedef struct packed {
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
    logic [LIM_W-1:0]  lo_sq;
    logic [LIM_W-1:0]  hi_sq;
  } rule_t;

  // Controller to datapath
  typedef struct packed {
    logic             store;
    logic             start;
    logic             issue;
    logic [IDX_W-1:0] rule_idx;
    logic             load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

  // Squared limit in point units from a limit in tenths of a millimetre
  function automatic logic [LIM_W-1:0] lim_sq(input int tenth);
    int units;
    units  = tenth * 2;
    return LIM_W'(units * units);
  endfunction

  function automatic rule_t mk_rule(input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b,
                                    input int lo, input int hi);
    rule_t r;
    r.a     = a;
    r.b     = b;
    r.lo_sq = lim_sq(lo);
    r.hi_sq = lim_sq(hi);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] rule_count(input logic [GEST_W-1:0] g);
    logic [IDX_W-1:0] n;
    case (g)
      GEST_OPEN:        n = 3'd6;
      GEST_EMPTY_HOLD:  n = 3'd5;
      GEST_SOLID_HOLD:  n = 3'd5;
      GEST_POINT:       n = 3'd4;
      GEST_INDEX_TOUCH: n = 3'd4;
      GEST_PINKY_TOUCH: n = 3'd2;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic needs_palm_up(input logic [GEST_W-1:0] g);
    return (g == GEST_INDEX_TOUCH) || (g == GEST_PINKY_TOUCH);
  endfunction

  function automatic logic gesture_known(input logic [GEST_W-1:0] g);
    return g <= GEST_PINKY_TOUCH;
  endfunction

  // Distance windows, limits in tenths of a millimetre
  function automatic rule_t rule_lookup(input logic [GEST_W-1:0] g,
                                        input logic [IDX_W-1:0] idx);
    rule_t r;
    r = '0;
    case (g)
      GEST_OPEN: begin
        case (idx)
          3'd0:    r = mk_rule(SLOT_THUMB,  SLOT_PALM,  520, 1100);
          3'd1:    r = mk_rule(SLOT_INDEX,  SLOT_PALM,  650, 1120);
          3'd2:    r = mk_rule(SLOT_MIDDLE, SLOT_PALM,  690, 1160);
          3'd3:    r = mk_rule(SLOT_RING,   SLOT_PALM,  676, 1140);
          3'd4:    r = mk_rule(SLOT_INDEX,  SLOT_THUMB, 500, 10000);
          3'd5:    r = mk_rule(SLOT_PINKY,  SLOT_THUMB, 690, 10000);
          default: r = '0;
        endcase
      end
      GEST_EMPTY_HOLD: begin
        case (idx)
          3'd0:    r = mk_rule(SLOT_INDEX,  SLOT_THUMB, 300, 700);
          3'd1:    r = mk_rule(SLOT_INDEX,  SLOT_PALM,  300, 780);
          3'd2:    r = mk_rule(SLOT_MIDDLE, SLOT_PALM,  300, 920);
          3'd3:    r = mk_rule(SLOT_RING,   SLOT_PALM,  320, 860);
          3'd4:    r = mk_rule(SLOT_PINKY,  SLOT_PALM,  390, 680);
          default: r = '0;
        endcase
      end
      GEST_SOLID_HOLD: begin
        case (idx)
          3'd0:    r = mk_rule(SLOT_INDEX,  SLOT_THUMB, 300, 700);
          3'd1:    r = mk_rule(SLOT_INDEX,  SLOT_PALM,  160, 665);
          3'd2:    r = mk_rule(SLOT_MIDDLE, SLOT_PALM,  230, 540);
          3'd3:    r = mk_rule(SLOT_RING,   SLOT_PALM,  220, 510);
          3'd4:    r = mk_rule(SLOT_PINKY,  SLOT_PALM,  250, 480);
          default: r = '0;
        endcase
      end
      GEST_POINT: begin
        case (idx)
          3'd0:    r = mk_rule(SLOT_INDEX,  SLOT_PALM,  650, 1120);
          3'd1:    r = mk_rule(SLOT_MIDDLE, SLOT_PALM,  230, 540);
          3'd2:    r = mk_rule(SLOT_RING,   SLOT_PALM,  220, 510);
          3'd3:    r = mk_rule(SLOT_PINKY,  SLOT_PALM,  250, 480);
          default: r = '0;
        endcase
      end
      GEST_INDEX_TOUCH: begin
        case (idx)
          3'd0:    r = mk_rule(SLOT_INDEX,  SLOT_THUMB, 100, 300);
          3'd1:    r = mk_rule(SLOT_MIDDLE, SLOT_PALM,  690, 1160);
          3'd2:    r = mk_rule(SLOT_RING,   SLOT_PALM,  676, 1140);
          3'd3:    r = mk_rule(SLOT_PINKY,  SLOT_PALM,  650, 1010);
          default: r = '0;
        endcase
      end
      GEST_PINKY_TOUCH: begin
        case (idx)
          3'd0:    r = mk_rule(SLOT_INDEX,  SLOT_THUMB, 650, 1120);
          3'd1:    r = mk_rule(SLOT_PINKY,  SLOT_THUMB, 100, 680);
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/hgdm_if.sv
// ----------------------------------------------------------------------------
// hgdm_if
// Valid/ready channel interfaces for input items and results.
// ----------------------------------------------------------------------------
interface hgdm_item_if;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [2:0]          slot;
  logic signed [15:0]  coord_x;
  logic signed [15:0]  coord_y;
  logic signed [15:0]  coord_z;
  logic [2:0]          gesture;

  modport source (output valid, kind, slot, coord_x, coord_y, coord_z, gesture,
                  input ready);
  modport sink   (input valid, kind, slot, coord_x, coord_y, coord_z, gesture,
                  output ready);
endinterface

interface hgdm_result_if;
  logic valid;
  logic ready;
  logic match;
  logic palm_up;

  modport source (output valid, match, palm_up, input ready);
  modport sink   (input valid, match, palm_up, output ready);
endinterface

### hw/rtl/hgdm_dp.sv
// ----------------------------------------------------------------------------
// hgdm_dp
// Datapath: point store, two-stage distance pipeline, window accumulator and
// result register.
// ----------------------------------------------------------------------------
module hgdm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  hgdm_pkg::cmd_t                cmd,
  input  logic [hgdm_pkg::SLOT_W-1:0]   in_slot,
  input  logic signed [15:0]            in_x,
  input  logic signed [15:0]            in_y,
  input  logic signed [15:0]            in_z,
  input  logic [hgdm_pkg::GEST_W-1:0]   in_gesture,
  output hgdm_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          match,
  output logic                          palm_up
);
  import hgdm_pkg::*;

  // Point store, one entry per slot, x in the low bits
  logic [3*COORD_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;

  logic [GEST_W-1:0] gesture_r;
  logic              palm_up_r;
  logic              ok_acc;

  rule_t             rule;

  // Stage 1: read both points
  logic                 v1;
  logic [3*COORD_W-1:0] rd_a;
  logic [3*COORD_W-1:0] rd_b;
  logic                 va1;
  logic                 vb1;
  logic [LIM_W-1:0]     lo1;
  logic [LIM_W-1:0]     hi1;

  // Stage 2: squared components
  logic                 v2;
  logic [SQ_W-1:0]      sq2 [3];
  logic [LIM_W-1:0]     lo2;
  logic [LIM_W-1:0]     hi2;

  logic [3*COORD_W-1:0] pa;
  logic [3*COORD_W-1:0] pb;
  logic [COORD_W-1:0]   mag [3];
  logic [DIST_W-1:0]    dist_sq;
  logic                 pass;

  assign rule = rule_lookup(gesture_r, cmd.rule_idx);

  // Write the point store; an out-of-range slot is dropped
  always_ff @(posedge clk) begin
    if (cmd.store && (in_slot < SLOT_W'(NUM_SLOTS))) begin
      mem[in_slot] <= {in_z, in_y, in_x};
    end
  end

  // Track written slots; an unwritten slot reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.store && (in_slot < SLOT_W'(NUM_SLOTS))) begin
      slot_valid[in_slot] <= 1'b1;
    end
  end

  // Latch gesture and palm orientation of an evaluate transaction
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      gesture_r <= in_gesture;
      palm_up_r <= (in_x < NORMAL_HALF) && (in_y < 0) && (in_z < 0);
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    rd_a <= mem[rule.a];
    rd_b <= mem[rule.b];
    va1  <= slot_valid[rule.a];
    vb1  <= slot_valid[rule.b];
    lo1  <= rule.lo_sq;
    hi1  <= rule.hi_sq;
  end

  // Per-axis absolute difference
  always_comb begin
    logic signed [COORD_W:0] diff;
    pa = va1 ? rd_a : '0;
    pb = vb1 ? rd_b : '0;
    for (int k = 0; k < 3; k++) begin
      diff   = 17'(signed'(pa[k*COORD_W +: COORD_W])) - 17'(signed'(pb[k*COORD_W +: COORD_W]));
      mag[k] = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    end
  end

  // Stage 2 registers: one square per axis
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq2[k] <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
    end
    lo2 <= lo1;
    hi2 <= hi1;
  end

  // Sum and window compare
  assign dist_sq = DIST_W'(sq2[0]) + DIST_W'(sq2[1]) + DIST_W'(sq2[2]);
  assign pass    = (dist_sq >= DIST_W'(lo2)) && (dist_sq <= DIST_W'(hi2));

  // Advance pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  // Accumulate window results
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ok_acc <= 1'b1;
    end else if (v2) begin
      ok_acc <= ok_acc & pass;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      match   <= gesture_known(gesture_r) && ok_acc &&
                 (!needs_palm_up(gesture_r) || palm_up_r);
      palm_up <= palm_up_r;
    end
  end

  assign status.pipe_busy = v1 | v2;
  assign status.out_free  = !out_valid || out_ready;

  // Stages advance in order
  a_stage_order: assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("distance stage 2 valid without stage 1");

  // No result load while rules are still in flight
  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!v1 && !v2))
    else $error("result loaded before pipeline drained");

  // A new evaluation never starts over an unfinished one
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (!v1 && !v2 && !cmd.issue))
    else $error("evaluation started while pipeline busy");

endmodule

### hw/rtl/hgdm_ctrl.sv
// ----------------------------------------------------------------------------
// hgdm_ctrl
// Controller: accepts transactions, steps through the gesture's rules and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module hgdm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_kind,
  input  logic [hgdm_pkg::GEST_W-1:0] in_gesture,
  output logic                        in_ready,
  input  hgdm_pkg::status_t           status,
  output hgdm_pkg::cmd_t              cmd
);
  import hgdm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] rule_idx;
  logic [IDX_W-1:0] rule_idx_next;
  logic [IDX_W-1:0] rule_cnt;
  logic [IDX_W-1:0] rule_cnt_next;
  logic             accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    rule_idx_next = rule_idx;
    rule_cnt_next = rule_cnt;
    cmd           = '0;
    cmd.rule_idx  = rule_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_STORE)) begin
          cmd.store = 1'b1;
        end else if (accept) begin
          cmd.start     = 1'b1;
          rule_idx_next = '0;
          rule_cnt_next = rule_count(in_gesture);
          state_next    = (rule_count(in_gesture) == '0) ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (rule_idx == rule_cnt - IDX_W'(1)) begin
          state_next = ST_DRAIN;
        end else begin
          rule_idx_next = rule_idx + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rule_idx <= '0;
      rule_cnt <= '0;
    end else begin
      state    <= state_next;
      rule_idx <= rule_idx_next;
      rule_cnt <= rule_cnt_next;
    end
  end

  // Rule index stays inside the gesture's rule list
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (rule_idx < rule_cnt))
    else $error("rule index beyond rule count");

  // Result is only handed over when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded over a waiting result");

endmodule

### hw/rtl/hand_gesture_distance_match.sv
// ----------------------------------------------------------------------------
// hand_gesture_distance_match
// Classifies a tracked hand pose from stored fingertip and palm points.
// ----------------------------------------------------------------------------
// Usage:
//   item   (sink)   store transactions (kind 0) write one point into a slot;
//                   evaluate transactions (kind 1) carry the palm normal and
//                   a gesture code.
//   result (source) one transaction per evaluate: match and palm_up.
// Timing:
//   A store keeps the input ready; the next transaction is accepted at once.
//   An evaluate steps through the gesture's N distance rules (N = 2..6, 0 for
//   unknown codes) one per cycle through a two-stage read/square pipeline;
//   the controller then waits until the pipeline has drained and the result
//   register is free, loads the result and makes the input ready again.
//   The input is not ready during an evaluate, so evaluates never overlap in
//   the single distance pipeline.
// Reset:
//   rst (synchronous) clears the control state and marks every point slot as
//   unwritten, so unwritten points read as zero.
// Stall:
//   The result register holds a finished result until it is taken; the block
//   keeps accepting stores meanwhile, and the next evaluate waits only if it
//   finishes while the previous result is still waiting.
// ----------------------------------------------------------------------------
module hand_gesture_distance_match (
  input  logic         clk,
  input  logic         rst,
  hgdm_item_if.sink    item,
  hgdm_result_if.source result
);
  import hgdm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign item.ready = in_ready;

  hgdm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_kind    (item.kind),
    .in_gesture (item.gesture),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  hgdm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_slot    (item.slot),
    .in_x       (item.coord_x),
    .in_y       (item.coord_y),
    .in_z       (item.coord_z),
    .in_gesture (item.gesture),
    .status     (status),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .match      (result.match),
    .palm_up    (result.palm_up)
  );

endmodule
